// File: hw/rtl/bdct_pkg.sv
// Shared types and constants of the button debounce and click timer block.
package bdct_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned DebounceW = 16;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 72;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [DebounceW-1:0] DebounceReset = 16'd20;
  localparam logic                 ReleasedReset = 1'b1;

  // Register indexes, taken from paddr[2].
  localparam logic RegDebounce = 1'b0;
  localparam logic RegReleased = 1'b1;

  typedef struct packed {
    logic [DebounceW-1:0] debounce_ms;
    logic                 released_level_high;
  } cfg_t;

  typedef struct packed {
    logic             take_click;
    logic [TimeW-1:0] now_ms;
    logic             raw_level;
  } item_t;

  typedef struct packed {
    logic [TimeW-1:0] last_period_ms;
    logic [TimeW-1:0] active_time_ms;
    logic             click_seen;
    logic             triggered;
    logic             stable_high;
  } result_t;

endpackage

// File: hw/rtl/button_debounce_click_timer_top.sv
// Top level of the button debounce and click timer: stream registers around the core.
//
//  channel  | direction | handshake          | payload
//  s_*      | in        | s_tvalid/s_tready  | s_tdata: raw_level, now_ms, take_click
//  m_*      | out       | m_tvalid/m_tready  | m_tdata: result fields
//  APB      | in        | psel/penable       | debounce_ms @0, released_level_high @4
//
// One item per cycle sustained while the output is not stalled; each item is held in the input
// register and its result is updated into the output register on the edge it leaves it.
// Reset (synchronous, rst) empties both registers and clears the debounce state.
// A stalled output holds its result; the input register then takes one more item
// and holds it, and s_tready stays low until the output moves on.
module button_debounce_click_timer_top
  import bdct_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // s_tdata: [0] raw_level, [32:1] now_ms, [33] take_click, [39:34] zero
  input  logic [InDataW-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // m_tdata: [0] stable_high, [1] triggered, [2] click_seen,
  //          [34:3] active_time_ms, [66:35] last_period_ms, [71:67] zero
  output logic [OutDataW-1:0] m_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    advance;
  result_t result;
  result_t out_result;

  bdct_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bdct_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (in_item),
    .advance (advance),
    .result  (result)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= s_tdata[$bits(item_t)-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_tdata = {{(OutDataW-$bits(result_t)){1'b0}}, out_result};

endmodule

// File: hw/rtl/bdct_regs.sv
// Configuration registers behind the APB-style port.
module bdct_regs
  import bdct_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms         <= DebounceReset;
      cfg.released_level_high <= ReleasedReset;
    end else if (wr_en) begin
      case (paddr[2])
        RegDebounce: cfg.debounce_ms         <= pwdata[DebounceW-1:0];
        RegReleased: cfg.released_level_high <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegDebounce: prdata = {{(CfgDataW-DebounceW){1'b0}}, cfg.debounce_ms};
      RegReleased: prdata = {{(CfgDataW-1){1'b0}}, cfg.released_level_high};
      default:     prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/bdct_core.sv
// Debounce state and the single-pass update for one sample.
module bdct_core
  import bdct_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  item_t   item,
  input  logic    advance,
  output result_t result
);

  logic             started;
  logic             raw_seen;
  logic             stable_level;
  logic             previous_stable;
  logic [TimeW-1:0] change_time;
  logic [TimeW-1:0] stable_since;
  logic [TimeW-1:0] last_period;
  logic             click_latch;

  logic             raw_seen_next;
  logic             stable_level_next;
  logic             previous_stable_next;
  logic [TimeW-1:0] change_time_next;
  logic [TimeW-1:0] stable_since_next;
  logic [TimeW-1:0] last_period_next;
  logic             click_latch_next;

  logic [TimeW-1:0] deb;
  logic [TimeW-1:0] since_clamped;
  logic             restart;
  logic             settle;
  logic             seen;

  assign deb           = {{(TimeW-DebounceW){1'b0}}, cfg.debounce_ms};
  assign since_clamped = (stable_since > item.now_ms) ? item.now_ms : stable_since;
  assign restart       = !started || (change_time > item.now_ms);
  assign settle        = !restart && (raw_seen == item.raw_level) &&
                         (raw_seen != stable_level) &&
                         ((item.now_ms - change_time) >= deb);

  always_comb begin
    raw_seen_next        = raw_seen;
    stable_level_next    = stable_level;
    previous_stable_next = previous_stable;
    change_time_next     = change_time;
    stable_since_next    = stable_since;
    last_period_next     = last_period;
    click_latch_next     = click_latch;
    seen                 = 1'b0;

    if (restart) begin
      raw_seen_next        = item.raw_level;
      stable_level_next    = item.raw_level;
      previous_stable_next = item.raw_level;
      stable_since_next    = item.now_ms;
      last_period_next     = '0;
      change_time_next     = item.now_ms;
    end else if (raw_seen != item.raw_level) begin
      change_time_next = item.now_ms;
      raw_seen_next    = item.raw_level;
    end else if (settle) begin
      last_period_next  = item.now_ms - since_clamped + deb;
      stable_since_next = item.now_ms;
      stable_level_next = raw_seen;
      if (previous_stable != raw_seen) begin
        // Release latches a click, a fresh press drops a pending one.
        click_latch_next     = (raw_seen == cfg.released_level_high);
        previous_stable_next = raw_seen;
      end
    end

    if (item.take_click) begin
      seen             = click_latch_next;
      click_latch_next = 1'b0;
    end
  end

  assign result.stable_high    = stable_level_next;
  assign result.triggered      = stable_level_next != cfg.released_level_high;
  assign result.click_seen     = seen;
  assign result.active_time_ms = (stable_since_next > item.now_ms) ? item.now_ms :
                                 item.now_ms - stable_since_next + deb;
  assign result.last_period_ms = last_period_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      started         <= 1'b0;
      raw_seen        <= 1'b0;
      stable_level    <= 1'b0;
      previous_stable <= 1'b0;
      change_time     <= '0;
      stable_since    <= '0;
      last_period     <= '0;
      click_latch     <= 1'b0;
    end else if (advance) begin
      started         <= 1'b1;
      raw_seen        <= raw_seen_next;
      stable_level    <= stable_level_next;
      previous_stable <= previous_stable_next;
      change_time     <= change_time_next;
      stable_since    <= stable_since_next;
      last_period     <= last_period_next;
      click_latch     <= click_latch_next;
    end
  end

endmodule

// File: hw/rtl/bdct_checker.sv
// Port-level checks of the button debounce and click timer, bound to the top level.
module bdct_checker
  import bdct_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata,
  input logic                pready
);

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output is empty");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind button_debounce_click_timer_top bdct_checker u_bdct_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .pready   (pready)
);

// File: tb/tb_top.sv
// Self-checking testbench of the button debounce and click timer top level.
module tb_top;
  import bdct_pkg::*;

  class debounce_tracker;
    logic [DebounceW-1:0] dbn_ms;
    logic                 rel_high;
    logic                 started;
    logic                 raw_seen;
    logic                 stable_lvl;
    logic                 prev_stable;
    logic                 click_latch;
    logic [TimeW-1:0]     change_t;
    logic [TimeW-1:0]     stable_since;
    logic [TimeW-1:0]     last_period;
    result_t              due_reports[$];
    int                   errors;
    int                   samples;
    int                   checked;
    int                   clicks;

    function new();
      dbn_ms       = DebounceReset;
      rel_high     = ReleasedReset;
      started      = 1'b0;
      raw_seen     = 1'b0;
      stable_lvl   = 1'b0;
      prev_stable  = 1'b0;
      click_latch  = 1'b0;
      change_t     = '0;
      stable_since = '0;
      last_period  = '0;
      errors       = 0;
      samples      = 0;
      checked      = 0;
      clicks       = 0;
    endfunction

    function void write_reg(logic idx, logic [CfgDataW-1:0] val);
      case (idx)
        RegDebounce: dbn_ms = val[DebounceW-1:0];
        RegReleased: rel_high = val[0];
        default: ;
      endcase
    endfunction

    // Work out the report for one accepted sample and queue it.
    function void note_sample(item_t it);
      result_t          rep;
      logic             seen;
      logic [TimeW-1:0] held_for;
      seen     = 1'b0;
      held_for = it.now_ms - change_t;
      samples++;
      if (!started || change_t > it.now_ms) begin
        // first sample, or time ran backwards: restart from this sample
        started      = 1'b1;
        raw_seen     = it.raw_level;
        stable_lvl   = it.raw_level;
        prev_stable  = it.raw_level;
        stable_since = it.now_ms;
        last_period  = '0;
        change_t     = it.now_ms;
      end else if (raw_seen != it.raw_level) begin
        change_t = it.now_ms;
        raw_seen = it.raw_level;
      end else if (raw_seen != stable_lvl && held_for >= TimeW'(dbn_ms)) begin
        // clamp a stable start that lies ahead of now
        if (stable_since > it.now_ms) stable_since = it.now_ms;
        last_period  = it.now_ms - stable_since + TimeW'(dbn_ms);
        stable_since = it.now_ms;
        stable_lvl   = raw_seen;
        if (prev_stable != stable_lvl) begin
          if (stable_lvl == rel_high) click_latch = 1'b1;
          else click_latch = 1'b0;
          prev_stable = stable_lvl;
        end
      end
      if (it.take_click) begin
        seen        = click_latch;
        click_latch = 1'b0;
      end
      rep.stable_high    = stable_lvl;
      rep.triggered      = (stable_lvl != rel_high);
      rep.click_seen     = seen;
      rep.active_time_ms = (stable_since > it.now_ms) ? it.now_ms
                                                       : it.now_ms - stable_since + TimeW'(dbn_ms);
      rep.last_period_ms = last_period;
      due_reports.push_back(rep);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_reports.size() == 0) begin
        $error("report arrived with no sample pending");
        errors++;
        return;
      end
      want = due_reports.pop_front();
      checked++;
      if (got.click_seen) clicks++;
      if (got.stable_high !== want.stable_high) begin
        $error("stable_high: expected %0d, got %0d", want.stable_high, got.stable_high);
        errors++;
      end
      if (got.triggered !== want.triggered) begin
        $error("triggered: expected %0d, got %0d", want.triggered, got.triggered);
        errors++;
      end
      if (got.click_seen !== want.click_seen) begin
        $error("click_seen: expected %0d, got %0d", want.click_seen, got.click_seen);
        errors++;
      end
      if (got.active_time_ms !== want.active_time_ms) begin
        $error("active_time_ms: expected %0d, got %0d", want.active_time_ms,
               got.active_time_ms);
        errors++;
      end
      if (got.last_period_ms !== want.last_period_ms) begin
        $error("last_period_ms: expected %0d, got %0d", want.last_period_ms,
               got.last_period_ms);
        errors++;
      end
    endfunction

    function int backlog();
      return due_reports.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  // s_tdata: [0] raw_level, [32:1] now_ms, [33] take_click, [39:34] zero
  logic [InDataW-1:0]  s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  // m_tdata: [0] stable_high, [1] triggered, [2] click_seen,
  //          [34:3] active_time_ms, [66:35] last_period_ms, [71:67] zero
  logic [OutDataW-1:0] m_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  debounce_tracker  tracker;
  logic [TimeW-1:0] clock_ms;
  logic             cur_raw;
  int               burst_left;
  int               settings;
  bit               hold_req;
  int               hold_left;
  int               holds;
  int unsigned      rx_tick;

  button_debounce_click_timer_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: check every accepted report, stall on a rotating pattern.
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1)
      tracker.check_result(m_tdata[$bits(result_t)-1:0]);
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_req) begin
      // hold off long enough for the block to fill and stall its input
      hold_req  = 1'b0;
      hold_left = 300;
      holds++;
      m_tready <= 1'b0;
    end else begin
      rx_tick++;
      case (rx_tick[7:6])
        2'd0: m_tready <= 1'b1;
        2'd1: m_tready <= ($urandom_range(0, 3) != 0);
        2'd2: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= (rx_tick % 3 == 0);
      endcase
    end
  end

  task automatic apb_write(logic idx, logic [CfgDataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.write_reg(idx, val);
    @(posedge clk);
  endtask

  // Offer one item until taken, then carry on the burst or drop into a gap.
  task automatic push_item(item_t it);
    s_tdata  <= {{(InDataW-$bits(item_t)){1'b0}}, it};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    tracker.note_sample(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                : $urandom_range(0, 8);
    end
  endtask

  task automatic drive_pin(logic raw, logic [TimeW-1:0] now, logic take);
    item_t it;
    it.raw_level  = raw;
    it.now_ms     = now;
    it.take_click = take;
    clock_ms      = now;
    cur_raw       = raw;
    push_item(it);
  endtask

  // Pause the sender until every report is back.
  task automatic wait_idle();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (tracker.backlog() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Mostly clean presses and releases with bounces; some noise, backward steps
  // and jumps anywhere in the time range.
  task automatic run_samples(int n, int unsigned step_max);
    int          sent;
    int unsigned kind;
    logic        lvl;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        lvl = ~cur_raw;
        repeat ($urandom_range(0, 3)) begin
          drive_pin(lvl, clock_ms + $urandom_range(0, 2), $urandom_range(0, 2) == 0);
          drive_pin(~lvl, clock_ms + $urandom_range(0, 2), $urandom_range(0, 2) == 0);
          sent += 2;
        end
        repeat ($urandom_range(2, 6)) begin
          drive_pin(lvl, clock_ms + $urandom_range(0, step_max),
                    $urandom_range(0, 2) == 0);
          sent++;
        end
      end else if (kind == 7) begin
        drive_pin(1'($urandom_range(0, 1)), clock_ms + $urandom_range(0, step_max),
                  1'($urandom_range(0, 1)));
        sent++;
      end else if (kind == 8) begin
        drive_pin(1'($urandom_range(0, 1)), clock_ms - $urandom_range(1, step_max),
                  1'($urandom_range(0, 1)));
        sent++;
      end else begin
        if ($urandom_range(0, 1)) drive_pin(cur_raw, $urandom(), 1'($urandom_range(0, 1)));
        else drive_pin(cur_raw, {24'hFFFFFF, 8'($urandom())}, 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  task automatic random_phase(logic [DebounceW-1:0] dbn, logic rel, int n,
                              int unsigned step_max, bit squeeze);
    wait_idle();
    // junk in the upper bits must be dropped by the block
    apb_write(RegDebounce, {16'($urandom()), dbn});
    apb_write(RegReleased, {31'($urandom()), rel});
    settings++;
    if (squeeze) begin
      hold_req   = 1'b1;
      burst_left = 80;
    end
    run_samples(n, step_max);
  endtask

  initial begin
    logic [DebounceW-1:0] dbn;
    tracker    = new();
    clock_ms   = '0;
    cur_raw    = 1'b0;
    burst_left = 0;
    settings   = 1;
    hold_req   = 1'b0;
    hold_left  = 0;
    holds      = 0;
    rx_tick    = 0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    m_tready <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: first sample, bounced press, release with click, time
    // running backwards, top of the time range and wrap to zero
    drive_pin(1'b1, 32'd1000, 1'b1);
    drive_pin(1'b0, 32'd1005, 1'b0);
    drive_pin(1'b1, 32'd1007, 1'b0);
    drive_pin(1'b0, 32'd1008, 1'b0);
    drive_pin(1'b0, 32'd1027, 1'b0);
    drive_pin(1'b0, 32'd1028, 1'b1);
    drive_pin(1'b1, 32'd1040, 1'b0);
    drive_pin(1'b1, 32'd1060, 1'b0);
    drive_pin(1'b1, 32'd1061, 1'b1);
    drive_pin(1'b1, 32'd500, 1'b0);
    drive_pin(1'b0, 32'hFFFF_FFFF, 1'b1);
    drive_pin(1'b0, 32'd0, 1'b0);

    // zero debounce, and a stable start lying ahead of now at a level change
    wait_idle();
    apb_write(RegDebounce, 32'd0);
    settings++;
    drive_pin(1'b1, 32'd100, 1'b0);
    drive_pin(1'b1, 32'd110, 1'b0);
    drive_pin(1'b0, 32'd105, 1'b0);
    drive_pin(1'b0, 32'd107, 1'b1);
    drive_pin(1'b0, 32'd107, 1'b0);

    // longest debounce with released reading low
    wait_idle();
    apb_write(RegDebounce, 32'd65535);
    apb_write(RegReleased, 32'd0);
    settings++;
    drive_pin(1'b0, 32'h8000_0000, 1'b0);
    drive_pin(1'b1, 32'h8000_0001, 1'b0);
    drive_pin(1'b1, 32'h8001_0000, 1'b0);
    drive_pin(1'b0, 32'h8001_0001, 1'b0);
    drive_pin(1'b0, 32'h8002_0000, 1'b1);

    random_phase(16'd20, 1'b1, 120, 12, 1'b1);
    random_phase(16'd0, 1'b0, 100, 3, 1'b0);
    random_phase(16'd65535, 1'b1, 80, 33000, 1'b1);
    dbn = DebounceW'($urandom_range(1, 60));
    random_phase(dbn, 1'($urandom_range(0, 1)), 150, dbn / 2 + 3, 1'b1);
    random_phase(16'd1, 1'b1, 150, 2, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Covered %0d samples under %0d register settings; %0d reports checked.",
             tracker.samples, settings, tracker.checked);
    $display("Clicks read back: %0d; long receiver hold-offs: %0d.", tracker.clicks, holds);
    if (tracker.errors == 0 && tracker.backlog() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
